[rtl/huffman_code_table_engine_macros.svh]
// Assertion macros used by the checker file of the code table engine.
`ifndef HUFFMAN_CODE_TABLE_ENGINE_MACROS_SVH
`define HUFFMAN_CODE_TABLE_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HCTE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HCTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hcte_pkg.sv]
// Shared constants, types and helpers for the code table engine.
`timescale 1ns / 1ps

package hcte_pkg;

  // Table geometry
  localparam int MAX_CODE_BITS = 12;
  localparam int SYMBOL_BITS   = 12;
  localparam int LEN_W         = 4;
  localparam int ENTRY_W       = LEN_W + 12;
  localparam int RAM_ADDR_W    = 12;   // covers both tables (2^12 entries each)
  localparam int RAM_DEPTH     = 1 << RAM_ADDR_W;
  localparam int CB_W          = 4;
  localparam int SC_W          = 13;
  localparam int SPAN_W        = MAX_CODE_BITS + 1;

  // Register reset values
  localparam logic [CB_W-1:0] CODE_BITS_RESET    = 4'd8;
  localparam logic [SC_W-1:0] SYMBOL_COUNT_RESET = 13'd256;

  // Register indexes on the config port
  localparam logic REG_CODE_BITS    = 1'b0;
  localparam logic REG_SYMBOL_COUNT = 1'b1;

  // Item commands
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_ENCODE = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // Effective configuration seen by the datapath
  typedef struct packed {
    logic [CB_W-1:0] cb_eff;
    logic [SC_W-1:0] symbol_count;
  } cfg_t;

  // One write port and one read port of a table RAM
  typedef struct packed {
    logic                  we;
    logic [RAM_ADDR_W-1:0] waddr;
    logic [ENTRY_W-1:0]    wdata;
    logic                  re;
    logic [RAM_ADDR_W-1:0] raddr;
  } ram_req_t;

  // Window width clamp: 0 acts as 1, above the maximum acts as the maximum
  function automatic logic [CB_W-1:0] eff_code_bits(input logic [CB_W-1:0] raw);
    logic [CB_W-1:0] res;
    if (raw == '0) begin
      res = CB_W'(1);
    end else if (raw > CB_W'(MAX_CODE_BITS)) begin
      res = CB_W'(MAX_CODE_BITS);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

[rtl/hcte_ram.sv]
// Table RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module hcte_ram (
  input  logic                             clk,
  input  hcte_pkg::ram_req_t               req,
  output logic [hcte_pkg::ENTRY_W-1:0]     rdata
);

  logic [hcte_pkg::ENTRY_W-1:0] mem [hcte_pkg::RAM_DEPTH];

  // Write and registered read; read data holds between reads
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

[rtl/hcte_regs.sv]
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module hcte_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output hcte_pkg::cfg_t       cfg
);

  logic [hcte_pkg::CB_W-1:0] code_bits;
  logic [hcte_pkg::SC_W-1:0] symbol_count;
  logic                      wr_en;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits    <= hcte_pkg::CODE_BITS_RESET;
      symbol_count <= hcte_pkg::SYMBOL_COUNT_RESET;
    end else if (wr_en) begin
      if (reg_sel == hcte_pkg::REG_CODE_BITS) begin
        code_bits <= pwdata[hcte_pkg::CB_W-1:0];
      end else begin
        symbol_count <= pwdata[hcte_pkg::SC_W-1:0];
      end
    end
  end

  // Readback
  always_comb begin
    if (reg_sel == hcte_pkg::REG_CODE_BITS) begin
      prdata = {{(32-hcte_pkg::CB_W){1'b0}}, code_bits};
    end else begin
      prdata = {{(32-hcte_pkg::SC_W){1'b0}}, symbol_count};
    end
  end

  assign cfg.cb_eff       = hcte_pkg::eff_code_bits(code_bits);
  assign cfg.symbol_count = symbol_count;

endmodule

[rtl/hcte_ctrl.sv]
// Sequencer: range checks, clear sweep, decode fill, lookups and result register.
`timescale 1ns / 1ps

module hcte_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  hcte_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      cmd,
  input  logic [11:0]                     symbol,
  input  logic [3:0]                      code_length,
  input  logic [11:0]                     code_value,
  input  logic [11:0]                     window,
  output hcte_pkg::ram_req_t              enc_req,
  input  logic [hcte_pkg::ENTRY_W-1:0]    enc_rdata,
  output hcte_pkg::ram_req_t              dec_req,
  input  logic [hcte_pkg::ENTRY_W-1:0]    dec_rdata,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [3:0]                      length_out,
  output logic [11:0]                     value_out,
  output logic                            error
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_FILL  = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  localparam int SW = hcte_pkg::SPAN_W;

  state_t                              state, state_next;
  logic [hcte_pkg::RAM_ADDR_W-1:0]     clr_addr;
  logic [SW-1:0]                       fill_j;
  logic [SW-1:0]                       fill_step;
  logic [SW-1:0]                       fill_span;
  logic [11:0]                         fill_code;
  logic [hcte_pkg::ENTRY_W-1:0]        fill_entry;
  hcte_pkg::cmd_t                      item_cmd;
  logic                                item_err;

  hcte_pkg::cmd_t                      cmd_in;
  logic                                accept;
  logic                                sym_bad, len_bad, win_bad, in_err;
  logic [SW-1:0]                       span;
  logic [SW-1:0]                       step_in;
  logic [11:0]                         code_in;
  logic [SW-1:0]                       step_sum;
  logic                                out_load;
  logic                                clr_done;
  logic [hcte_pkg::ENTRY_W-1:0]        rd_sel;

  assign cmd_in   = hcte_pkg::cmd_t'(cmd);
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Operand range checks
  assign span    = SW'(1) << cfg.cb_eff;
  assign step_in = SW'(1) << code_length;
  assign code_in = code_value & 12'(step_in - SW'(1));
  assign sym_bad = {1'b0, symbol} >= cfg.symbol_count;
  assign len_bad = code_length > cfg.cb_eff;
  assign win_bad = {1'b0, window} >= span;

  always_comb begin
    case (cmd_in)
      hcte_pkg::CMD_INSERT: in_err = sym_bad || len_bad;
      hcte_pkg::CMD_DECODE: in_err = win_bad;
      hcte_pkg::CMD_ENCODE: in_err = sym_bad;
      default:              in_err = 1'b1;
    endcase
  end

  // Encode table: written at insert accept, read at encode accept
  always_comb begin
    enc_req.we    = accept && (cmd_in == hcte_pkg::CMD_INSERT) && !in_err;
    enc_req.waddr = symbol;
    enc_req.wdata = {code_in, code_length};
    enc_req.re    = accept && (cmd_in == hcte_pkg::CMD_ENCODE);
    enc_req.raddr = symbol;
  end

  // Decode table: clear sweep or fill writes, read at decode accept.
  // The sequencer never reads while writing, so no forwarding is needed.
  always_comb begin
    dec_req.we    = (state == ST_CLEAR) || (state == ST_FILL);
    dec_req.waddr = (state == ST_CLEAR) ? clr_addr : (fill_code | fill_j[11:0]);
    dec_req.wdata = (state == ST_CLEAR) ? '0 : fill_entry;
    dec_req.re    = accept && (cmd_in == hcte_pkg::CMD_DECODE);
    dec_req.raddr = window;
  end

  assign step_sum = fill_j + fill_step;
  assign clr_done = (clr_addr == '1);
  assign out_load = (state == ST_RESP) && (!out_valid || !out_stall);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (cmd_in == hcte_pkg::CMD_INSERT && !in_err) state_next = ST_FILL;
          else                                           state_next = ST_RESP;
        end
      end
      ST_FILL: begin
        if (step_sum >= fill_span) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  // Item capture and fill stepping
  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd   <= cmd_in;
      item_err   <= in_err;
      fill_j     <= '0;
      fill_step  <= step_in;
      fill_span  <= span;
      fill_code  <= code_in;
      fill_entry <= {symbol, code_length};
    end else if (state == ST_FILL) begin
      fill_j <= step_sum;
    end
  end

  // Result select
  always_comb begin
    case (item_cmd)
      hcte_pkg::CMD_DECODE: rd_sel = dec_rdata;
      hcte_pkg::CMD_ENCODE: rd_sel = enc_rdata;
      default:              rd_sel = '0;
    endcase
    if (item_err) rd_sel = '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      length_out <= rd_sel[3:0];
      value_out  <= rd_sel[hcte_pkg::ENTRY_W-1:4];
      error      <= item_err;
    end
  end

endmodule

[rtl/huffman_code_table_engine.sv]
// Top level of the code table engine: registers, sequencer and the two table RAMs.
//
// Input channel (in_valid/in_stall) carries one item per beat: cmd, symbol,
// code_length, code_value, window. Output channel (out_valid/out_stall)
// returns exactly one result beat per item: length_out, value_out, error.
// Config registers code_bits and symbol_count sit at byte addresses 0 and 4
// of the APB-style port; write them only while the block is idle.
// Sequencing: a lookup reads a table RAM, then loads the result register;
// a rejected item loads it directly; no new item is taken until the result
// is loaded. An accepted insert first writes 2^(code_bits - code_length)
// decode entries through the single decode RAM write port, one per cycle.
// Reset: registers return to code_bits 8, symbol_count 256, then a clear
// sweep writes zero to all 4096 decode entries, one per cycle; in_stall is
// high until the sweep ends. The encode table is not cleared.
// Stall: a finished result waits in the output register while the next
// item is accepted; that item's result waits in the sequencer until the
// output register frees.
`timescale 1ns / 1ps

module huffman_code_table_engine (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   cmd,
  input  logic [11:0]  symbol,
  input  logic [3:0]   code_length,
  input  logic [11:0]  code_value,
  input  logic [11:0]  window,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [3:0]   length_out,
  output logic [11:0]  value_out,
  output logic         error
);

  hcte_pkg::cfg_t                   cfg;
  hcte_pkg::ram_req_t               enc_req;
  hcte_pkg::ram_req_t               dec_req;
  logic [hcte_pkg::ENTRY_W-1:0]     enc_rdata;
  logic [hcte_pkg::ENTRY_W-1:0]     dec_rdata;

  // Config registers
  hcte_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Encode table: symbol -> {code, length}
  hcte_ram u_enc_ram (
    .clk   (clk),
    .req   (enc_req),
    .rdata (enc_rdata)
  );

  // Decode table: window -> {symbol, length}
  hcte_ram u_dec_ram (
    .clk   (clk),
    .req   (dec_req),
    .rdata (dec_rdata)
  );

  // Sequencer and result register
  hcte_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .symbol      (symbol),
    .code_length (code_length),
    .code_value  (code_value),
    .window      (window),
    .enc_req     (enc_req),
    .enc_rdata   (enc_rdata),
    .dec_req     (dec_req),
    .dec_rdata   (dec_rdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .length_out  (length_out),
    .value_out   (value_out),
    .error       (error)
  );

endmodule

[rtl/hcte_checker.sv]
// Port-level checks on the code table engine, bound to the top level.
`timescale 1ns / 1ps
`include "huffman_code_table_engine_macros.svh"

module hcte_checker (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_stall,
  input logic         out_valid,
  input logic         out_stall,
  input logic [3:0]   length_out,
  input logic [11:0]  value_out,
  input logic         error
);

  // Rejected items report zero fields
  `HCTE_ASSERT_SAME(a_err_zero, out_valid && error, (length_out == 4'd0) && (value_out == 12'd0), "error beat with nonzero fields")

  // Code lengths never exceed the widest window
  `HCTE_ASSERT_SAME(a_len_range, out_valid, length_out <= 4'd12, "length_out beyond maximum code length")

  // One item in flight: the beat after an accept is stalled
  `HCTE_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item accepted while one is in work")

  // A stalled result beat holds
  `HCTE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(length_out) && $stable(value_out) && $stable(error), "stalled result beat changed")

endmodule

bind huffman_code_table_engine hcte_checker u_hcte_checker (.*);
